### rtl/bc_pkg.sv
package bc_pkg;

    // Result width and default argument width
    localparam int VALUE_WIDTH       = 64;
    localparam int ARG_WIDTH_DEFAULT = 16;
    localparam int CNT_WIDTH         = $clog2(VALUE_WIDTH);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_CHECK,
        ST_DIV,
        ST_DECIDE,
        ST_MUL,
        ST_MUL_END,
        ST_DONE
    } bc_state_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic load;
        logic clr_acc;
        logic div_start;
        logic div_step;
        logic div_commit;
        logic mul_start;
        logic mul_step;
        logic mul_commit;
        logic result_load;
    } bc_cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic spec_one;
        logic spec_zero;
        logic ri_lt_r;
        logic ni_lt_r;
        logic rem_zero;
        logic div_last;
        logic mul_last;
    } bc_stat_t;

endpackage

### rtl/bc_ctrl.sv
module bc_ctrl
    import bc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  bc_stat_t stat,
    output bc_cmd_t  cmd
);

    bc_state_t state_reg, state_next;
    logic      m_valid_reg, m_valid_next;

    // Advance state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_SETUP;
            end
            ST_SETUP: begin
                if (stat.spec_zero || stat.spec_one) state_next = ST_DONE;
                else                                 state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (stat.ri_lt_r)      state_next = ST_DIV;
                else if (stat.ni_lt_r) state_next = ST_MUL;
                else                   state_next = ST_DONE;
            end
            ST_DIV: begin
                if (stat.div_last) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (stat.rem_zero || !stat.ni_lt_r) state_next = ST_CHECK;
                else                                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (stat.mul_last) state_next = ST_MUL_END;
            end
            ST_MUL_END: begin
                state_next = ST_CHECK;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SETUP: begin
                cmd.clr_acc = stat.spec_zero;
            end
            ST_CHECK: begin
                cmd.div_start = stat.ri_lt_r;
                cmd.mul_start = !stat.ri_lt_r && stat.ni_lt_r;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_DECIDE: begin
                cmd.div_commit = stat.rem_zero || !stat.ni_lt_r;
                cmd.mul_start  = !(stat.rem_zero || !stat.ni_lt_r);
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
            end
            ST_MUL_END: begin
                cmd.mul_commit = 1'b1;
            end
            ST_DONE: begin
                cmd.result_load = !m_valid_reg || m_ready;
            end
            default: cmd = '0;
        endcase
    end

    // Hold result valid until the receiver takes the result
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.result_load)  m_valid_next = 1'b1;
        else if (m_ready)     m_valid_next = 1'b0;
    end

    assign m_valid = m_valid_reg;

endmodule

### rtl/bc_dp.sv
module bc_dp
    import bc_pkg::*;
#(
    parameter int ARG_WIDTH = ARG_WIDTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_op,
    input  logic [ARG_WIDTH-1:0]   s_n,
    input  logic [ARG_WIDTH-1:0]   s_r,
    input  bc_cmd_t                cmd,
    output bc_stat_t               stat,
    output logic [VALUE_WIDTH-1:0] m_value,
    output logic                   m_overflow
);

    localparam int NW = ARG_WIDTH + 1;
    localparam int PW = VALUE_WIDTH + NW;

    logic [NW-1:0]          ne_reg;
    logic                   neg_reg;
    logic [ARG_WIDTH-1:0]   r_reg, ri_reg, ni_reg;
    logic [ARG_WIDTH-1:0]   r_next, ri_next, ni_next;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic                   ovf_reg;
    logic [VALUE_WIDTH-1:0] dq_reg;
    logic [ARG_WIDTH-1:0]   rem_reg;
    logic [ARG_WIDTH-1:0]   divisor_reg;
    logic [NW-1:0]          mreg_reg;
    logic [PW-1:0]          prod_reg;
    logic [CNT_WIDTH-1:0]   cnt_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   ovf_out_reg;

    logic [NW-1:0]          ne_next;
    logic [ARG_WIDTH:0]     trial;
    logic [ARG_WIDTH:0]     trial_sub;
    logic                   q_bit;
    logic [PW-1:0]          prod_next;
    logic [NW-1:0]          factor;

    // Effective n: n, or n+r-1 in repetition mode
    always_comb begin
        if (s_op) ne_next = {1'b0, s_n} + {1'b0, s_r} - NW'(1);
        else      ne_next = {1'b0, s_n};
    end

    // One restoring divide step
    always_comb begin
        trial     = {rem_reg, dq_reg[VALUE_WIDTH-1]};
        q_bit     = trial >= {1'b0, divisor_reg};
        trial_sub = trial - {1'b0, divisor_reg};
    end

    // One shift-add multiply step, factor bits MSB first
    assign factor    = ne_reg - {1'b0, ni_reg};
    assign prod_next = {prod_reg[PW-2:0], 1'b0}
                     + (mreg_reg[NW-1] ? {{NW{1'b0}}, acc_reg} : {PW{1'b0}});

    // Step counters
    always_comb begin
        r_next  = r_reg;
        ri_next = ri_reg;
        ni_next = ni_reg;
        if (cmd.load) begin
            r_next  = s_r;
            ri_next = '0;
            ni_next = '0;
        end else begin
            if (cmd.div_commit) ri_next = ri_reg + ARG_WIDTH'(1);
            if (cmd.mul_commit) ni_next = ni_reg + ARG_WIDTH'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_reg  <= '0;
            ri_reg <= '0;
            ni_reg <= '0;
        end else begin
            r_reg  <= r_next;
            ri_reg <= ri_next;
            ni_reg <= ni_next;
        end
    end

    // Operands and running value
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ne_reg  <= ne_next;
            neg_reg <= s_op && (s_n == '0) && (s_r == '0);
            acc_reg <= VALUE_WIDTH'(1);
            ovf_reg <= 1'b0;
        end else begin
            if (cmd.clr_acc)    acc_reg <= '0;
            if (cmd.div_commit) acc_reg <= dq_reg;
            if (cmd.mul_commit) begin
                acc_reg <= prod_reg[VALUE_WIDTH-1:0];
                ovf_reg <= ovf_reg | (|prod_reg[PW-1:VALUE_WIDTH]);
            end
        end
    end

    // Shared divider and multiplier registers
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dq_reg      <= acc_reg;
            rem_reg     <= '0;
            divisor_reg <= r_reg - ri_reg;
            cnt_reg     <= '0;
        end else if (cmd.div_step) begin
            dq_reg  <= {dq_reg[VALUE_WIDTH-2:0], q_bit};
            rem_reg <= q_bit ? trial_sub[ARG_WIDTH-1:0] : trial[ARG_WIDTH-1:0];
            cnt_reg <= cnt_reg + CNT_WIDTH'(1);
        end else if (cmd.mul_start) begin
            prod_reg <= '0;
            mreg_reg <= factor;
            cnt_reg  <= '0;
        end else if (cmd.mul_step) begin
            prod_reg <= prod_next;
            mreg_reg <= {mreg_reg[NW-2:0], 1'b0};
            cnt_reg  <= cnt_reg + CNT_WIDTH'(1);
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            value_reg   <= acc_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    // Status
    always_comb begin
        stat.spec_zero = !neg_reg && ({1'b0, r_reg} > ne_reg);
        stat.spec_one  = neg_reg || (r_reg == '0) || (ne_reg == NW'(1))
                       || ({1'b0, r_reg} == ne_reg);
        stat.ri_lt_r   = ri_reg < r_reg;
        stat.ni_lt_r   = ni_reg < r_reg;
        stat.rem_zero  = rem_reg == '0;
        stat.div_last  = cnt_reg == CNT_WIDTH'(VALUE_WIDTH - 1);
        stat.mul_last  = cnt_reg == CNT_WIDTH'(NW - 1);
    end

    assign m_value    = value_reg;
    assign m_overflow = ovf_out_reg;

    // Divisions never run past r
    a_ri_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ri_reg <= r_reg) else $error("division count passed r");

    // Multiplications never run past r
    a_ni_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ni_reg <= r_reg) else $error("multiply count passed r");

    // A division is committed only while divisors remain
    a_div_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_commit |-> stat.ri_lt_r) else $error("division commit with no divisor left");

    // A product is committed only while factors remain
    a_mul_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_commit |-> stat.ni_lt_r) else $error("product commit with no factor left");

endmodule

### rtl/binomial_coefficient_top.sv
// Binomial coefficient unit.
// Input channel s_valid/s_ready carries one request: s_op (0 = n choose r,
// 1 = choose with repetition, (n+r-1) choose r), s_n and s_r. Result channel
// m_valid/m_ready returns m_value (the coefficient modulo 2^64) and
// m_overflow (set if any intermediate product exceeded 64 bits).
// One request is worked at a time; s_ready is high only while the unit idles.
// Special cases (r above n, r zero, n one, r equal to n) go from setup straight
// to done. Otherwise the value is built by exact divisions by r, r-1, ..., 1
// and multiplications by n, n-1, ..., n-r+1 on one shared bit-serial divider
// and one bit-serial multiplier. Each division attempt shifts out 64 quotient
// bits and then decides, each multiplication steps through ARG_WIDTH+1 factor
// bits; an item runs r divisions, r multiplications and the failed division
// attempts that precede multiplications, so its latency is data dependent.
// The result sits in an output register: while the receiver stalls, it holds,
// and the next request may be accepted and worked; only finishing that next
// request waits for the output register to free up.
// Reset (aresetn low, synchronous) returns to idle and drops any result.
module binomial_coefficient_top
    import bc_pkg::*;
#(
    parameter int ARG_WIDTH = ARG_WIDTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_op,
    input  logic [ARG_WIDTH-1:0]   s_n,
    input  logic [ARG_WIDTH-1:0]   s_r,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [VALUE_WIDTH-1:0] m_value,
    output logic                   m_overflow
);

    bc_cmd_t  cmd;
    bc_stat_t stat;

    // Sequencer
    bc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath
    bc_dp #(
        .ARG_WIDTH (ARG_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_op       (s_op),
        .s_n        (s_n),
        .s_r        (s_r),
        .cmd        (cmd),
        .stat       (stat),
        .m_value    (m_value),
        .m_overflow (m_overflow)
    );

endmodule

### dv/binomial_coefficient_top_tb.sv
module binomial_coefficient_top_tb;
    import bc_pkg::*;

    localparam int ARG_W      = ARG_WIDTH_DEFAULT;
    localparam int RAND_COUNT = 1225;
    localparam int IDLE_LIMIT = 40000;
    localparam int HOLD_OFF   = 3000;
    localparam int MAX_SHOWN  = 10;

    // Request modes
    localparam logic OP_CHOOSE   = 1'b0;
    localparam logic OP_MULTISET = 1'b1;

    typedef logic [ARG_W-1:0] arg_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   overflow;
    } coeff_t;

    typedef struct packed {
        logic                   op;
        arg_t                   n;
        arg_t                   r;
        logic                   typed;
        logic [VALUE_WIDTH-1:0] value;
        logic                   overflow;
    } dir_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_op;
    arg_t                   s_n;
    arg_t                   s_r;
    logic                   m_valid;
    logic                   m_ready;
    logic [VALUE_WIDTH-1:0] m_value;
    logic                   m_overflow;

    coeff_t pending_coeffs [$];
    int     fail_count    = 0;
    int     results_seen  = 0;
    int     overflow_seen = 0;
    int     multiset_sent = 0;
    int     requests_sent = 0;
    int     widest_r      = 0;
    int     idle_cycles   = 0;
    bit     steady        = 1'b0;
    bit     hold_done     = 1'b0;

    // Directed requests: typed results only where they are obvious
    dir_row_t dir_rows [0:24] = '{
        '{OP_CHOOSE,   16'd0,      16'd0,     1'b1, 64'd1,     1'b0},
        '{OP_CHOOSE,   16'd5,      16'd6,     1'b1, 64'd0,     1'b0},
        '{OP_CHOOSE,   16'd0,      16'd65535, 1'b1, 64'd0,     1'b0},
        '{OP_CHOOSE,   16'd65534,  16'd65535, 1'b1, 64'd0,     1'b0},
        '{OP_CHOOSE,   16'd65535,  16'd65535, 1'b1, 64'd1,     1'b0},
        '{OP_CHOOSE,   16'd65535,  16'd0,     1'b1, 64'd1,     1'b0},
        '{OP_CHOOSE,   16'd1,      16'd0,     1'b1, 64'd1,     1'b0},
        '{OP_CHOOSE,   16'd1,      16'd1,     1'b1, 64'd1,     1'b0},
        '{OP_CHOOSE,   16'd1,      16'd2,     1'b1, 64'd0,     1'b0},
        '{OP_CHOOSE,   16'd2,      16'd2,     1'b1, 64'd1,     1'b0},
        '{OP_MULTISET, 16'd0,      16'd0,     1'b1, 64'd1,     1'b0},
        '{OP_MULTISET, 16'd0,      16'd65535, 1'b1, 64'd0,     1'b0},
        '{OP_MULTISET, 16'd1,      16'd65535, 1'b1, 64'd1,     1'b0},
        '{OP_MULTISET, 16'd65535,  16'd0,     1'b1, 64'd1,     1'b0},
        '{OP_MULTISET, 16'd2,      16'd1,     1'b0, 64'd0,     1'b0},
        '{OP_CHOOSE,   16'd10,     16'd3,     1'b0, 64'd0,     1'b0},
        '{OP_CHOOSE,   16'd65535,  16'd1,     1'b1, 64'd65535, 1'b0},
        '{OP_CHOOSE,   16'd65535,  16'd2,     1'b0, 64'd0,     1'b0},
        '{OP_CHOOSE,   16'd65535,  16'd6,     1'b0, 64'd0,     1'b0},
        '{OP_CHOOSE,   16'd64,     16'd32,    1'b0, 64'd0,     1'b0},
        '{OP_CHOOSE,   16'd67,     16'd33,    1'b0, 64'd0,     1'b0},
        '{OP_MULTISET, 16'd3,      16'd4,     1'b0, 64'd0,     1'b0},
        '{OP_MULTISET, 16'd65535,  16'd3,     1'b0, 64'd0,     1'b0},
        '{OP_CHOOSE,   16'hAAAA,   16'd3,     1'b0, 64'd0,     1'b0},
        '{OP_MULTISET, 16'h5555,   16'd5,     1'b0, 64'd0,     1'b0}
    };

    binomial_coefficient_top #(
        .ARG_WIDTH(ARG_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_n       (s_n),
        .s_r       (s_r),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_value   (m_value),
        .m_overflow(m_overflow)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Compute the wrapped coefficient and overflow flag for one request
    function automatic coeff_t predict_coefficient(input logic op_i, input arg_t n_i,
                                                   input arg_t r_i);
        coeff_t                 res;
        logic [63:0]            top;
        logic [63:0]            cnt;
        logic [63:0]            acc;
        logic [63:0]            muls;
        logic [63:0]            divs;
        logic [63:0]            dv;
        logic [63:0]            fac;
        logic [127:0]           prod;
        res.value    = 64'd1;
        res.overflow = 1'b0;
        cnt          = 64'(r_i);
        if (op_i == OP_MULTISET) begin
            if (n_i == '0 && r_i == '0)
                return res;
            top = 64'(n_i) + 64'(r_i) - 64'd1;
        end else begin
            top = 64'(n_i);
        end
        if (cnt > top) begin
            res.value = 64'd0;
            return res;
        end
        if (cnt == 64'd0 || top == 64'd1 || cnt == top)
            return res;
        acc  = 64'd1;
        muls = 64'd0;
        divs = 64'd0;
        // Divide exactly when possible, otherwise pull in the next factor
        while (divs < cnt || muls < cnt) begin
            dv = cnt - divs;
            if (divs < cnt && (acc % dv == 64'd0 || muls >= cnt)) begin
                acc  = acc / dv;
                divs = divs + 64'd1;
            end else begin
                fac  = top - muls;
                prod = {64'd0, acc} * {64'd0, fac};
                if (prod[127:64] != 64'd0)
                    res.overflow = 1'b1;
                acc  = prod[63:0];
                muls = muls + 64'd1;
            end
        end
        res.value = acc;
        return res;
    endfunction

    // Offer one request, hold it until taken, then queue its expected result
    task automatic issue_request(input logic op_i, input arg_t n_i, input arg_t r_i,
                                 input logic typed_i, input coeff_t typed_res);
        if (!steady && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op_i;
        s_n     <= n_i;
        s_r     <= r_i;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (typed_i)
            pending_coeffs.push_back(typed_res);
        else
            pending_coeffs.push_back(predict_coefficient(op_i, n_i, r_i));
        requests_sent++;
        if (op_i == OP_MULTISET)
            multiset_sent++;
    endtask

    // Stimulus: reset, directed table, then weighted random requests
    initial begin
        logic   op;
        arg_t   n;
        arg_t   r;
        coeff_t typed_res;
        int     pick;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_op    <= OP_CHOOSE;
        s_n     <= '0;
        s_r     <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            typed_res.value    = dir_rows[i].value;
            typed_res.overflow = dir_rows[i].overflow;
            issue_request(dir_rows[i].op, dir_rows[i].n, dir_rows[i].r,
                          dir_rows[i].typed, typed_res);
            if (int'(dir_rows[i].r) > widest_r && dir_rows[i].r < 16'd100)
                widest_r = int'(dir_rows[i].r);
        end

        for (int i = 0; i < RAND_COUNT; i++) begin
            steady = (i >= 400 && i < 560);
            pick   = $urandom_range(0, 99);
            op     = 1'($urandom_range(0, 1));
            n      = arg_t'($urandom);
            r      = arg_t'($urandom);
            if (pick < 25) begin
                // Cheap corners: r above n, r equal to n, r zero, n one
                case ($urandom_range(0, 3))
                    0: begin
                        if (op == OP_MULTISET)
                            n = '0;
                        else if (r < n)
                            {n, r} = {r, n};
                    end
                    1: begin
                        if (op == OP_MULTISET)
                            n = arg_t'(1);
                        else
                            n = r;
                    end
                    2: r = '0;
                    default: begin
                        op = OP_CHOOSE;
                        n  = arg_t'(1);
                    end
                endcase
            end else begin
                // Worked requests: keep r small so each stays short
                if (pick < 88)
                    r = arg_t'($urandom_range(1, 6));
                else if (pick < 98)
                    r = arg_t'($urandom_range(7, 10));
                else
                    r = arg_t'($urandom_range(11, 24));
                if ($urandom_range(0, 1) == 0)
                    n = arg_t'($urandom_range(0, 70));
                if (int'(r) > widest_r)
                    widest_r = int'(r);
            end
            issue_request(op, n, r, 1'b0, typed_res);
        end
        s_valid <= 1'b0;
        steady  = 1'b0;

        // Drain outstanding results, then allow a short settle
        while (pending_coeffs.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        fail_count += pending_coeffs.size();

        $display("covered %0d requests (%0d with repetition), widest worked r %0d",
                 requests_sent, multiset_sent, widest_r);
        $display("checked %0d results, %0d with overflow set, %0d failures",
                 results_seen, overflow_seen, fail_count);
        if (fail_count == 0) begin
            $display("binomial_coefficient_top_tb: clean");
        end else begin
            $display("binomial_coefficient_top_tb: errors");
        end
        $finish;
    end

    // Receiver: random stalls, one long hold-off to back up the input
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!hold_done && results_seen >= 300) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // Check each returned coefficient against the oldest expectation
    always @(posedge aclk) begin
        coeff_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_overflow)
                overflow_seen++;
            if (pending_coeffs.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("unexpected result value %0h overflow %0b",
                             m_value, m_overflow);
            end else begin
                want = pending_coeffs.pop_front();
                if (m_value !== want.value || m_overflow !== want.overflow) begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("result %0d: expected value %0h overflow %0b, got %0h %0b",
                                 results_seen, want.value, want.overflow,
                                 m_value, m_overflow);
                end
            end
        end
    end

    // Watchdog: abort when nothing moves on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d cycles without a request or result",
                         IDLE_LIMIT);
                $display("binomial_coefficient_top_tb: errors");
                $finish;
            end
        end
    end

endmodule
